FILE: sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the button sequence collector
// Event codes, opcodes, register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int unsigned MaxDigitsDef  = 16;
  localparam int unsigned NumButtonsDef = 9;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SEQ_W   = 64;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned BTN_W   = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned EV_W    = 3;

  localparam logic [CFG_W-1:0] BounceResetMs = 16'd250;
  localparam logic [CFG_W-1:0] IdleResetMs   = 16'd2000;

  typedef enum logic [EV_W-1:0] {
    EV_IDLE   = 3'd0,
    EV_STORED = 3'd1,
    EV_BOUNCE = 3'd2,
    EV_FULL   = 3'd3,
    EV_DONE   = 3'd4
  } bsc_event_e;

  typedef enum logic {
    OP_PRESS = 1'b0,
    OP_TICK  = 1'b1
  } bsc_opcode_e;

  typedef enum logic {
    CFG_IDX_BOUNCE = 1'b0,
    CFG_IDX_IDLE   = 1'b1
  } bsc_cfg_idx_e;

  typedef struct packed {
    bsc_event_e         ev;
    logic [SEQ_W-1:0]   digits;
    logic [LEN_W-1:0]   length;
  } bsc_result_t;

endpackage

`default_nettype wire

FILE: sv/bsc_seq_state.sv
// ----------------------------------------------------------------------------
// bsc_seq_state: sequence state and per-transaction decision
// Holds last press time, digit store and count; computes the result of one
// press or tick and commits the state update when step_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_seq_state
  import bsc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS  = MaxDigitsDef,
  parameter int unsigned NUM_BUTTONS = NumButtonsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              opcode_i,
  input  wire logic [BTN_W-1:0]  button_i,
  input  wire logic [TIME_W-1:0] now_ms_i,
  input  wire logic [CFG_W-1:0]  bounce_ms_i,
  input  wire logic [CFG_W-1:0]  idle_ms_i,
  output bsc_result_t            result_o
);

  logic [TIME_W-1:0] last_q, last_d;
  logic              seen_q, seen_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic [SEQ_W-1:0]  digits_q, digits_d;

  logic [TIME_W-1:0] gap;
  logic              gap_nonneg;
  logic              btn_ok;
  logic              bounce;
  logic              full;
  logic              done;

  assign gap        = now_ms_i - last_q;
  assign gap_nonneg = ~gap[TIME_W-1];
  assign btn_ok     = (button_i != '0) && (button_i <= BTN_W'(NUM_BUTTONS));
  assign bounce     = seen_q && gap_nonneg && (gap < {{(TIME_W-CFG_W){1'b0}}, bounce_ms_i});
  assign full       = count_q >= LEN_W'(MAX_DIGITS);
  assign done       = seen_q && gap_nonneg && (gap >= {{(TIME_W-CFG_W){1'b0}}, idle_ms_i});

  always_comb begin
    last_d      = last_q;
    seen_d      = seen_q;
    count_d     = count_q;
    digits_d    = digits_q;
    result_o.ev = EV_IDLE;
    if (opcode_i == OP_TICK) begin
      // tick reports the sequence as held before any clear
      if (done) begin
        result_o.ev = EV_DONE;
        last_d      = '0;
        seen_d      = 1'b0;
        count_d     = '0;
        digits_d    = '0;
      end
      result_o.digits = digits_q;
      result_o.length = count_q;
    end else begin
      if (btn_ok) begin
        if (bounce) begin
          result_o.ev = EV_BOUNCE;
        end else begin
          last_d = now_ms_i;
          seen_d = 1'b1;
          if (full) begin
            result_o.ev = EV_FULL;
          end else begin
            result_o.ev = EV_STORED;
            count_d     = count_q + LEN_W'(1);
            for (int k = 0; k < int'(MAX_DIGITS); k++) begin
              if (count_q == LEN_W'(k)) begin
                digits_d[k*DIGIT_W +: DIGIT_W] = button_i;
              end
            end
          end
        end
      end
      // press reports the sequence after the update
      result_o.digits = digits_d;
      result_o.length = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      seen_q   <= 1'b0;
      count_q  <= '0;
      digits_q <= '0;
    end else if (step_i) begin
      last_q   <= last_d;
      seen_q   <= seen_d;
      count_q  <= count_d;
      digits_q <= digits_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/button_sequence_collector.sv
// ----------------------------------------------------------------------------
// button_sequence_collector: debounced keypad code collector
// Stores button presses as digits and reports the code after an idle time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per press
//   (opcode 0, button, now_ms) or tick (opcode 1, now_ms). Every input
//   transaction yields exactly one output transaction on out_valid_o /
//   out_stall_i: event code, packed digits and length.
//   Path: an accepted transaction is captured in the input register; its
//   result is then loaded into the output register and is visible on the
//   outputs from then on. Throughput: one transaction per cycle while
//   out_stall_i is low. The debounce subtract/compare and the state update
//   sit in the single stage between input and output registers, so each
//   item sees the state left by the one before it.
//   Stall: while out_stall_i holds a result in the output register, the item
//   in the input register waits and in_stall_o rises; one more item can be
//   taken while the input register is empty.
//   Reset: clears both valids, the sequence state, and loads the bounce
//   window (250 ms) and idle timeout (2000 ms) defaults.
//   Configuration: cfg_wr_en_i writes cfg_wdata_i to register cfg_idx_i
//   (0 bounce window, 1 idle timeout); write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module button_sequence_collector
  import bsc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS  = MaxDigitsDef,
  parameter int unsigned NUM_BUTTONS = NumButtonsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write port
  input  wire logic              cfg_wr_en_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              opcode_i,
  input  wire logic [BTN_W-1:0]  button_i,
  input  wire logic [TIME_W-1:0] now_ms_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [EV_W-1:0]        event_res_o,
  output logic [SEQ_W-1:0]       seq_digits_o,
  output logic [LEN_W-1:0]       seq_length_o
);

  // configuration registers
  logic [CFG_W-1:0] bounce_ms_q;
  logic [CFG_W-1:0] idle_ms_q;

  // input register
  logic              s1_valid_q, s1_valid_d;
  logic              s1_op_q;
  logic [BTN_W-1:0]  s1_btn_q;
  logic [TIME_W-1:0] s1_now_q;

  // output register
  logic              out_valid_q, out_valid_d;
  bsc_result_t       out_res_q;
  bsc_result_t       res;

  logic in_accept;
  logic advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_ms_q <= BounceResetMs;
      idle_ms_q   <= IdleResetMs;
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        CFG_IDX_BOUNCE: bounce_ms_q <= cfg_wdata_i;
        CFG_IDX_IDLE:   idle_ms_q   <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Stage moves when the output register is empty or being drained.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q  <= opcode_i;
      s1_btn_q <= button_i;
      s1_now_q <= now_ms_i;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  bsc_seq_state #(
    .MAX_DIGITS  (MAX_DIGITS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .opcode_i    (s1_op_q),
    .button_i    (s1_btn_q),
    .now_ms_i    (s1_now_q),
    .bounce_ms_i (bounce_ms_q),
    .idle_ms_i   (idle_ms_q),
    .result_o    (res)
  );

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = out_res_q.ev;
  assign seq_digits_o = out_res_q.digits;
  assign seq_length_o = out_res_q.length;

`ifndef SYNTHESIS
  // stored digit count never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.length <= LEN_W'(MAX_DIGITS)))
    else $error("sequence length beyond store depth");

  // a dropped-for-full press always shows a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.ev == EV_FULL) |-> (out_res_q.length == LEN_W'(MAX_DIGITS)))
    else $error("full event with store not full");

  // a stored press always leaves at least one digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.ev == EV_STORED) |-> (out_res_q.length != '0))
    else $error("stored event with empty sequence");

  // input stall only ever comes from a waiting item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked item");
`endif

endmodule

`default_nettype wire

FILE: bench/button_sequence_collector_tb.sv
// ----------------------------------------------------------------------------
// button_sequence_collector_tb: self-checking bench for the keypad collector
// Drives press and tick transactions with random gaps and output stalls,
// predicts each result from a local copy of the collector state, and
// compares every result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module button_sequence_collector_tb
  import bsc_pkg::*;
();

  // Generous bound: ~700 transactions, each with the longest sender pause
  // plus the longest receiver stall, taken several times over.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 40;

  // DUT ports
  logic              clk_i;
  logic              rst_ni;
  logic              cfg_wr_en_i;
  logic              cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              opcode_i;
  logic [BTN_W-1:0]  button_i;
  logic [TIME_W-1:0] now_ms_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [EV_W-1:0]   event_res_o;
  logic [SEQ_W-1:0]  seq_digits_o;
  logic [LEN_W-1:0]  seq_length_o;

  // Predicted collector state and register copies
  logic [CFG_W-1:0]  bounce_ms_q;
  logic [CFG_W-1:0]  idle_ms_q;
  logic [TIME_W-1:0] last_press_q;
  logic              press_seen_q;
  int unsigned       digit_count_q;
  logic [SEQ_W-1:0]  code_digits_q;

  // Results still owed by the DUT, oldest first
  bsc_result_t       expected_events[$];

  int unsigned       mismatches;
  int unsigned       cycles;
  int unsigned       useful_items;   // transactions that the collector acts on
  int unsigned       rx_hold;        // stall cycles left before next result
  bit                tx_calm;        // sender in a no-gap stretch
  bit                rx_calm;        // receiver in a no-stall stretch
  logic [TIME_W-1:0] wall_ms;        // running time base for code entries

  button_sequence_collector DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .button_i     (button_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_res_o  (event_res_o),
    .seq_digits_o (seq_digits_o),
    .seq_length_o (seq_length_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Wait length for one transaction. Now and then flips into or out of a
  // calm stretch where no waiting happens at all.
  function automatic int unsigned draw_pause(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // --------------------------------------------------------------------------
  // Prediction: one result per accepted transaction
  // --------------------------------------------------------------------------
  task automatic predict_keypad_event(input bsc_opcode_e op, input logic [BTN_W-1:0] btn,
                                      input logic [TIME_W-1:0] now);
    bsc_result_t       r;
    logic [TIME_W-1:0] gap;
    logic              gap_ok;
    // signed 32-bit gap; only a non-negative gap can bounce or time out
    gap    = now - last_press_q;
    gap_ok = press_seen_q && !gap[TIME_W-1];
    r.ev   = EV_IDLE;
    if (op == OP_PRESS) begin
      if (btn >= 1 && btn <= NumButtonsDef) begin
        useful_items++;
        if (gap_ok && gap < {16'h0, bounce_ms_q}) begin
          r.ev = EV_BOUNCE;
        end else begin
          // passes debounce: refresh last press even when the store is full
          last_press_q = now;
          press_seen_q = 1'b1;
          if (digit_count_q >= MaxDigitsDef) begin
            r.ev = EV_FULL;
          end else begin
            code_digits_q[DIGIT_W*digit_count_q +: DIGIT_W] = btn;
            digit_count_q++;
            r.ev = EV_STORED;
          end
        end
      end
      r.digits = code_digits_q;
      r.length = LEN_W'(digit_count_q);
    end else begin
      useful_items++;
      // completion shows the digits held before clearing
      r.digits = code_digits_q;
      r.length = LEN_W'(digit_count_q);
      if (gap_ok && gap >= {16'h0, idle_ms_q}) begin
        r.ev          = EV_DONE;
        last_press_q  = '0;
        press_seen_q  = 1'b0;
        digit_count_q = 0;
        code_digits_q = '0;
      end
    end
    expected_events.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Driving: inputs move at the falling edge, handshakes seen at the rising
  // --------------------------------------------------------------------------
  task automatic send_item(input bsc_opcode_e op, input logic [BTN_W-1:0] btn,
                           input logic [TIME_W-1:0] now);
    int unsigned pause;
    pause = draw_pause(tx_calm);
    @(negedge clk_i);
    if (pause > 0) begin
      in_valid_i = 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    opcode_i   = op;
    button_i   = btn;
    now_ms_i   = now;
    in_valid_i = 1'b1;
    // payload holds until an edge with stall low takes it
    do @(posedge clk_i); while (in_stall_o);
    predict_keypad_event(op, btn, now);
  endtask

  // Drop valid and let every owed result come back, then wait out a margin
  // for the output register.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_register(input bsc_cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_wr_en_i = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    case (idx)
      CFG_IDX_BOUNCE: bounce_ms_q = data;
      CFG_IDX_IDLE:   idle_ms_q   = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] bounce, input logic [CFG_W-1:0] idle);
    drain_results();
    write_register(CFG_IDX_BOUNCE, bounce);
    write_register(CFG_IDX_IDLE, idle);
  endtask

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t %s: expected %h actual %h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    bsc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        note_mismatch("unexpected transaction event", '0, event_res_o);
      end else begin
        want = expected_events.pop_front();
        if (event_res_o !== want.ev)
          note_mismatch("event_res", want.ev, event_res_o);
        if (seq_digits_o !== want.digits)
          note_mismatch("seq_digits", want.digits, seq_digits_o);
        if (seq_length_o !== want.length)
          note_mismatch("seq_length", want.length, seq_length_o);
      end
      rx_hold = draw_pause(rx_calm);
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i = 1'b1;
      rx_hold--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results owed", cycles, expected_events.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Tick out of reset has no press to time against; a bad button is ignored.
  task automatic test_tick_with_no_press();
    send_item(OP_TICK, 4'hF, 32'hFFFF_FFFF);
    send_item(OP_PRESS, 4'h0, 32'h0000_0000);
  endtask

  // Reset values of the registers: 250 ms bounce, 2000 ms idle timeout.
  task automatic test_default_debounce();
    send_item(OP_PRESS, 4'd3, 32'd1000);   // first press, no bounce check
    send_item(OP_PRESS, 4'd4, 32'd1249);   // 249 ms: bounce
    send_item(OP_PRESS, 4'd5, 32'd1250);   // 250 ms: stored
    send_item(OP_PRESS, 4'd6, 32'd900);    // negative gap: stored
    send_item(OP_TICK,  4'd0, 32'd2899);   // 1999 ms idle: not yet
    send_item(OP_TICK,  4'd0, 32'd800);    // negative idle gap: not done
    send_item(OP_TICK,  4'd0, 32'd2900);   // 2000 ms idle: complete
  endtask

  task automatic test_button_range();
    send_item(OP_PRESS, 4'd0,  32'd10000);  // below range: ignored
    send_item(OP_PRESS, 4'd15, 32'd10000);  // above range: ignored
    send_item(OP_PRESS, 4'd10, 32'd10000);
    send_item(OP_PRESS, 4'd1,  32'd10000);
    send_item(OP_PRESS, 4'd9,  32'd20000);
    send_item(OP_TICK,  4'd9,  32'd22000);
  endtask

  // Gaps taken modulo 2^32 across the wrap of the millisecond counter.
  task automatic test_time_wrap();
    send_item(OP_PRESS, 4'd7, 32'hFFFF_FFFF);
    send_item(OP_PRESS, 4'd8, 32'h0000_00F8);   // 249 ms later: bounce
    send_item(OP_PRESS, 4'd2, 32'h0000_00F9);   // 250 ms later: stored
    send_item(OP_TICK,  4'd0, 32'h0000_08C9);   // 2000 ms idle
  endtask

  // Widest bounce with a zero timeout, then no bounce with the widest timeout.
  task automatic test_register_extremes();
    set_timing(16'hFFFF, 16'h0000);
    send_item(OP_PRESS, 4'd1, 32'd0);
    send_item(OP_PRESS, 4'd2, 32'd65534);
    send_item(OP_PRESS, 4'd3, 32'd65535);
    send_item(OP_TICK,  4'd0, 32'd65535);       // zero gap completes
    set_timing(16'h0000, 16'hFFFF);
    send_item(OP_PRESS, 4'd4, 32'd100);
    send_item(OP_PRESS, 4'd5, 32'd100);         // zero gap, no window
    send_item(OP_TICK,  4'd0, 32'd65634);
    send_item(OP_TICK,  4'd0, 32'd65635);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------

  // One code entry: presses spaced mostly past the bounce window, with some
  // bounces, backward steps, early ticks, then usually a completing tick.
  task automatic enter_code_sequence();
    int unsigned       presses;
    int unsigned       bw;
    int unsigned       iw;
    int unsigned       pick;
    logic [BTN_W-1:0]  btn;
    logic [TIME_W-1:0] t;
    bw = bounce_ms_q;
    iw = idle_ms_q;
    presses = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 22) : $urandom_range(1, 8);
    if ($urandom_range(0, 7) == 0) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    t = wall_ms;
    repeat (presses) begin
      case ($urandom_range(0, 9))
        0:       t = t + ((bw == 0) ? 0 : $urandom_range(0, bw - 1));
        1:       t = t - $urandom_range(1, 5000);
        default: t = t + bw + $urandom_range(0, 3000);
      endcase
      if ($urandom_range(0, 24) == 0) begin
        pick = $urandom_range(0, 6);
        btn  = (pick == 0) ? 4'd0 : BTN_W'(pick + 9);
      end else begin
        btn  = BTN_W'($urandom_range(1, NumButtonsDef));
      end
      send_item(OP_PRESS, btn, t);
      if ($urandom_range(0, 7) == 0)
        send_item(OP_TICK, BTN_W'($urandom_range(0, 15)),
                  t + ((iw == 0) ? 0 : $urandom_range(0, iw - 1)));
    end
    // most entries finish; the rest are abandoned and run into the next one
    if ($urandom_range(0, 4) != 0)
      send_item(OP_TICK, BTN_W'($urandom_range(0, 15)), t + iw + $urandom_range(0, 100));
    wall_ms = t + iw + 200;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 5))
      send_item(bsc_opcode_e'($urandom_range(0, 1)), BTN_W'($urandom_range(0, 15)), $urandom);
  endtask

  task automatic run_random_phase(input int unsigned count);
    int unsigned stop_at;
    stop_at = useful_items + count;
    while (useful_items < stop_at) begin
      if ($urandom_range(0, 9) < 8) enter_code_sequence();
      else                          send_noise();
    end
  endtask

  task automatic test_random_phases();
    set_timing(BounceResetMs, IdleResetMs);
    run_random_phase(150);
    set_timing(16'h0000, 16'h0001);
    run_random_phase(150);
    set_timing(16'hFFFF, 16'hFFFF);
    run_random_phase(150);
    set_timing(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(1, 65535)));
    run_random_phase(150);
  endtask

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_idx_i     = CFG_IDX_BOUNCE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_PRESS;
    button_i      = '0;
    now_ms_i      = '0;
    out_stall_i   = 1'b0;
    bounce_ms_q   = BounceResetMs;
    idle_ms_q     = IdleResetMs;
    last_press_q  = '0;
    press_seen_q  = 1'b0;
    digit_count_q = 0;
    code_digits_q = '0;
    mismatches    = 0;
    cycles        = 0;
    useful_items  = 0;
    rx_hold       = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    wall_ms       = 32'd50000;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_tick_with_no_press();
    test_default_debounce();
    test_button_range();
    test_time_wrap();
    test_register_extremes();
    test_random_phases();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/bsc_pkg.sv
sv/bsc_seq_state.sv
sv/button_sequence_collector.sv
bench/button_sequence_collector_tb.sv
